>>> rtl/core/assert_macros.svh
// Assertion macros shared by the CRC-16 frame checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/crc16fc_pkg.sv
// Types, constants and the CRC byte update for the CRC-16 frame checker.
package crc16fc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [2:0]  FRAME_MIN     = 3'd5;
  localparam logic [7:0]  FRAME_MIN_LEN = 8'd5;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] data_length;
  } out_beat_t;

  // Handoff from the input stage to the frame engine.
  typedef struct packed {
    logic step;
    logic last;
  } step_ctrl_t;

  // One byte through CRC-16, MSB first, no reflection.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/crc16fc_in_stage.sv
// Input register stage: holds one byte beat and issues the step to the engine.
module crc16fc_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  crc16fc_pkg::in_beat_t in_data,
  input  logic                  out_free,
  output crc16fc_pkg::step_ctrl_t ctrl,
  output crc16fc_pkg::in_beat_t beat
);
  import crc16fc_pkg::*;

  logic beat_valid;

  // A closing byte needs a free result slot; other bytes always move on.
  always_comb begin
    ctrl.step = beat_valid && (!beat.last_byte || out_free);
    ctrl.last = beat.last_byte;
    in_ready  = !beat_valid || ctrl.step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ready) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat <= in_data;
    end
  end

endmodule

>>> rtl/core/crc16fc_engine.sv
// Frame engine: delay line, running CRC, header capture and result decode.
module crc16fc_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  crc16fc_pkg::step_ctrl_t ctrl,
  input  crc16fc_pkg::in_beat_t   beat,
  output crc16fc_pkg::out_beat_t  result
);
  import crc16fc_pkg::*;
  `include "assert_macros.svh"

  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held0, held1;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  frame_address, frame_length_field, frame_command;
  logic [15:0] trailer;
  logic        too_short;

  always_comb begin
    running_crc_next = (byte_count >= 3'd2) ? crc_feed(running_crc, held0) : running_crc;
    byte_count_next  = (byte_count < FRAME_MIN) ? byte_count + 3'd1 : byte_count;
    // trailer: low byte is the held newest byte, high byte the one arriving now
    trailer   = {beat.frame_byte, held1};
    // header bytes are already stored whenever the count can reach five
    too_short = (byte_count_next < FRAME_MIN) || (frame_length_field < FRAME_MIN_LEN);

    result.address     = 8'h00;
    result.command     = 8'h00;
    result.data_length = 8'h00;
    if (byte_count_next >= FRAME_MIN) begin
      result.address = frame_address;
      result.command = frame_command;
    end
    if (too_short) begin
      result.status = STATUS_SHORT;
    end else if (trailer != running_crc_next) begin
      result.status = STATUS_CRC_ERR;
    end else begin
      result.status      = STATUS_OK;
      result.data_length = frame_length_field - FRAME_MIN_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (ctrl.step && ctrl.last)) begin
      running_crc        <= '0;
      held0              <= '0;
      held1              <= '0;
      byte_count         <= '0;
      frame_address      <= '0;
      frame_length_field <= '0;
      frame_command      <= '0;
    end else if (ctrl.step) begin
      running_crc <= running_crc_next;
      held0       <= held1;
      held1       <= beat.frame_byte;
      byte_count  <= byte_count_next;
      if (byte_count == 3'd0) frame_address      <= beat.frame_byte;
      if (byte_count == 3'd1) frame_length_field <= beat.frame_byte;
      if (byte_count == 3'd2) frame_command      <= beat.frame_byte;
    end
  end

  `CHK_ASSERT(a_count_sat, byte_count <= FRAME_MIN, "byte count past saturation")
  `CHK_ASSERT(a_frame_clear, ctrl.step && ctrl.last |=> byte_count == 3'd0, "frame not cleared")

endmodule

>>> rtl/core/crc16fc_out_stage.sv
// Result register: holds one finished frame result until it is taken.
module crc16fc_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  crc16fc_pkg::out_beat_t result,
  output logic                   out_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output crc16fc_pkg::out_beat_t out_data
);
  import crc16fc_pkg::*;
  `include "assert_macros.svh"

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  `CHK_ASSERT(a_no_overwrite, load |-> out_free, "result loaded over a pending beat")

endmodule

>>> rtl/core/crc16_frame_checker_core.sv
// Top level of the CRC-16 frame checker.
// Checks received frames streamed one byte per beat (address, length,
// command, data, then a two-byte CRC trailer, low byte first) and returns
// one result beat per frame when the beat marked last_byte arrives: status
// (ok, too short, CRC mismatch), address, command and data length. CRC-16 is
// poly 0x1021, init 0, unreflected, over all bytes but the trailer. Rate is
// one byte beat per clock while the result register can take each result:
// the byte-wide CRC update and the trailer compare are combinational
// between the input register and the result register. The closing byte
// passes the input register and then the result register, which holds
// the result beat. Data bytes produce no output; a closing byte waits in the
// input register only while a previous result is still pending and stalled.
module crc16_frame_checker_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  crc16fc_pkg::in_beat_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output crc16fc_pkg::out_beat_t out_data
);
  import crc16fc_pkg::*;

  step_ctrl_t ctrl;       // engine step strobe and frame-close flag
  in_beat_t   beat;       // registered input byte
  out_beat_t  result;     // decoded frame result, valid on a closing step
  logic       out_free;   // result slot can take a new beat this cycle

  // input register and step control
  crc16fc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .ctrl     (ctrl),
    .beat     (beat)
  );

  // per-frame state and result decode
  crc16fc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .beat   (beat),
    .result (result)
  );

  // result register, loaded only on the closing byte of a frame
  crc16fc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (ctrl.step && ctrl.last),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/tb_crc16_frame_checker_core.sv
// Self-checking bench for crc16_frame_checker_core: framed byte stimulus vs. a local frame model.
module tb_crc16_frame_checker_core;
  import crc16fc_pkg::*;

  // Run limits. The slowest legal run is about 1600 beats, each with a possible
  // idle burst on the sender and stall burst on the receiver, plus one long
  // receiver hold-off. CYCLE_LIMIT lies well above that.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          RAND_BEATS   = 1600;
  localparam int          CALM_AFTER   = 1400;  // no idling past this many beats
  localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int          HOLD_AT      = 40;    // results seen before the hold-off
  localparam int          PAUSE_FRAME  = 60;    // random frame that waits for a full drain
  localparam int          DRAIN_CYCLES = 5000;
  localparam int          TAIL_CYCLES  = 10;    // idle cycles after the drain
  localparam int          MAX_REPORTS  = 10;

  // How a frame is closed: bytes as given (last one marked), or a computed
  // trailer that is correct, corrupted, or sent high byte first.
  typedef enum logic [1:0] {
    TRL_NONE,
    TRL_GOOD,
    TRL_BAD,
    TRL_SWAP
  } trl_mode_t;

  // Directed frame: up to six leading bytes, byte 0 in the low bits.
  typedef struct packed {
    logic [3:0]  nbytes;
    logic [47:0] body;
    trl_mode_t   mode;
    logic        typed;  // expected result given in the row
    out_beat_t   want;
  } dir_frame_t;

  localparam int DIR_ROWS = 6;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  crc16_frame_checker_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Frame model: running CRC, two-byte hold line, byte count (saturating at
  // five) and the three header bytes. Mirrors the block's per-byte behavior.
  // ---------------------------------------------------------------------
  logic [15:0] fr_crc;
  logic [7:0]  fr_hold_old;
  logic [7:0]  fr_hold_new;
  logic [2:0]  fr_count;
  logic [7:0]  fr_addr;
  logic [7:0]  fr_len;
  logic [7:0]  fr_cmd;

  out_beat_t   frame_results_q[$];  // expected result beats, oldest first
  out_beat_t   seen_want;
  int          errors       = 0;
  int          results_seen = 0;
  int          beats_sent   = 0;
  bit          calm         = 1'b0;
  int unsigned cycle_count  = 0;

  // Bit-serial CRC-16, poly 0x1021, MSB first.
  function automatic logic [15:0] crc_shift(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // CRC over every byte of the current frame so far, hold line included.
  function automatic logic [15:0] crc_of_frame_so_far();
    logic [15:0] c;
    c = fr_crc;
    if (fr_count >= 3'd2) begin
      c = crc_shift(c, fr_hold_old);
    end
    if (fr_count >= 3'd1) begin
      c = crc_shift(c, fr_hold_new);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    fr_crc      = '0;
    fr_hold_old = '0;
    fr_hold_new = '0;
    fr_count    = '0;
    fr_addr     = '0;
    fr_len      = '0;
    fr_cmd      = '0;
  endfunction

  // Advance the model by one accepted byte; a marked byte closes the frame.
  task automatic absorb_byte(input in_beat_t b, output bit closes, output out_beat_t res);
    logic [15:0] trailer;
    closes = 1'b0;
    res    = '0;
    // oldest held byte drops out of the hold line into the CRC
    if (fr_count >= 3'd2) begin
      fr_crc = crc_shift(fr_crc, fr_hold_old);
    end
    case (fr_count)
      3'd0: fr_addr = b.frame_byte;
      3'd1: fr_len  = b.frame_byte;
      3'd2: fr_cmd  = b.frame_byte;
      default: ;
    endcase
    fr_hold_old = fr_hold_new;
    fr_hold_new = b.frame_byte;
    if (fr_count < FRAME_MIN) begin
      fr_count = fr_count + 3'd1;
    end
    if (b.last_byte) begin
      closes  = 1'b1;
      trailer = {fr_hold_new, fr_hold_old};  // low byte arrived first
      if (fr_count >= FRAME_MIN) begin
        res.address = fr_addr;
        res.command = fr_cmd;
      end
      // too short wins over the CRC check
      if (fr_count < FRAME_MIN || fr_len < FRAME_MIN_LEN) begin
        res.status = STATUS_SHORT;
      end else if (trailer != fr_crc) begin
        res.status = STATUS_CRC_ERR;
      end else begin
        res.status      = STATUS_OK;
        res.data_length = fr_len - FRAME_MIN_LEN;
      end
      clear_frame();
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender: one beat per call, with random idle bursts before it. Valid
  // stays high until the beat is taken.
  // ---------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] d, input logic is_last, input bit typed,
                           input out_beat_t want);
    in_beat_t  b;
    bit        closes;
    out_beat_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    b.frame_byte = d;
    b.last_byte  = is_last;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    absorb_byte(b, closes, res);
    if (closes) begin
      frame_results_q.push_back(typed ? want : res);
    end
    beats_sent++;
    calm = (beats_sent >= CALM_AFTER);
  endtask

  // Leading bytes, then the trailer the mode asks for.
  task automatic send_frame(input logic [7:0] body[$], input trl_mode_t mode, input bit typed,
                            input out_beat_t want);
    logic [15:0] c;
    for (int i = 0; i < body.size(); i++) begin
      send_beat(body[i], (mode == TRL_NONE) && (i == body.size() - 1), typed, want);
    end
    if (mode != TRL_NONE) begin
      c = crc_of_frame_so_far();
      if (mode == TRL_BAD) begin
        c = c ^ (16'h0001 << $urandom_range(0, 15));
      end else if (mode == TRL_SWAP) begin
        c = {c[7:0], c[15:8]};
      end
      send_beat(c[7:0], 1'b0, typed, want);
      send_beat(c[15:8], 1'b1, typed, want);
    end
  endtask

  // Random frame: mostly well formed with random header and data, some with
  // a short length byte, broken or swapped trailers, and some cut short.
  task automatic send_random_frame();
    logic [7:0] body[$];
    int         kind;
    int         ndata;
    trl_mode_t  mode;
    body  = {};
    kind  = $urandom_range(0, 99);
    if (kind < 8) begin
      // fewer than five bytes, last one marked
      repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
      mode = TRL_NONE;
    end else begin
      ndata = ($urandom_range(0, 6) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      body.push_back(8'($urandom_range(0, 255)));
      if (kind < 14) begin
        body.push_back(8'($urandom_range(0, 4)));
      end else if ($urandom_range(0, 1) == 0) begin
        body.push_back(8'(ndata + 5));
      end else begin
        // length byte picked at random, not tied to the real count
        body.push_back(8'($urandom_range(5, 255)));
      end
      body.push_back(8'($urandom_range(0, 255)));
      repeat (ndata) body.push_back(8'($urandom_range(0, 255)));
      if (kind >= 14 && kind < 22) begin
        mode = TRL_BAD;
      end else if (kind >= 22 && kind < 27) begin
        mode = TRL_SWAP;
      end else begin
        mode = TRL_GOOD;
      end
    end
    send_frame(body, mode, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts and ready stretches, one long hold-off so
  // the block backs up into its input, and no stalls near the end.
  // ---------------------------------------------------------------------
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Result checker: every taken result beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (frame_results_q.size() == 0) begin
        if (errors < MAX_REPORTS) begin
          $display("result beat with nothing pending: st=%0d addr=%02h cmd=%02h dlen=%0d",
                   out_data.status, out_data.address, out_data.command,
                   out_data.data_length);
        end
        errors++;
      end else begin
        seen_want = frame_results_q.pop_front();
        if (out_data.status != seen_want.status || out_data.address != seen_want.address ||
            out_data.command != seen_want.command ||
            out_data.data_length != seen_want.data_length) begin
          if (errors < MAX_REPORTS) begin
            $display("mismatch: exp st=%0d addr=%02h cmd=%02h dlen=%0d", seen_want.status,
                     seen_want.address, seen_want.command, seen_want.data_length);
            $display("          got st=%0d addr=%02h cmd=%02h dlen=%0d", out_data.status,
                     out_data.address, out_data.command, out_data.data_length);
          end
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, directed frames, random frames, drain.
  // ---------------------------------------------------------------------
  initial begin
    dir_frame_t frame_tbl [DIR_ROWS];
    logic [7:0] body[$];
    int         nframes;
    int         waited;

    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    clear_frame();

    // single marked byte right after reset
    frame_tbl[0] = '{4'd1, 48'h0000_0000_0000, TRL_NONE, 1'b1,
                     '{STATUS_SHORT, 8'h00, 8'h00, 8'h00}};
    // four bytes, all ones: still too short, header fields zeroed
    frame_tbl[1] = '{4'd4, 48'h0000_FFFF_FFFF, TRL_NONE, 1'b1,
                     '{STATUS_SHORT, 8'h00, 8'h00, 8'h00}};
    // five bytes but length byte 4: short, address and command still reported
    frame_tbl[2] = '{4'd5, 48'h0034_1255_04AA, TRL_NONE, 1'b1,
                     '{STATUS_SHORT, 8'hAA, 8'h55, 8'h00}};
    // all-ones header with a good trailer: largest data length
    frame_tbl[3] = '{4'd3, 48'h0000_00FF_FFFF, TRL_GOOD, 1'b1,
                     '{STATUS_OK, 8'hFF, 8'hFF, 8'hFA}};
    // same header, trailer corrupted
    frame_tbl[4] = '{4'd3, 48'h0000_00FF_FFFF, TRL_BAD, 1'b1,
                     '{STATUS_CRC_ERR, 8'hFF, 8'hFF, 8'h00}};
    // trailer sent high byte first; one data byte
    frame_tbl[5] = '{4'd4, 48'h0000_3C80_0701, TRL_SWAP, 1'b0, '0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (frame_tbl[r]) begin
      body = {};
      for (int k = 0; k < frame_tbl[r].nbytes; k++) begin
        body.push_back(frame_tbl[r].body[8*k +: 8]);
      end
      send_frame(body, frame_tbl[r].mode, frame_tbl[r].typed, frame_tbl[r].want);
    end

    nframes = 0;
    while (beats_sent < RAND_BEATS) begin
      if (nframes == PAUSE_FRAME) begin
        // sender goes quiet until every pending result is out
        @(negedge clk);
        in_valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge clk);
      end
      send_random_frame();
      nframes++;
    end

    @(negedge clk);
    in_valid <= 1'b0;

    waited = 0;
    while (frame_results_q.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (frame_results_q.size() != 0) begin
      $display("%0d expected result beats never arrived", frame_results_q.size());
      errors += frame_results_q.size();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
